// ===== rtl/core/asc_pkg.sv =====
package asc_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PEAK_W   = 16;
  localparam int SUMSQ_W  = 51;
  localparam int COUNT_W  = 21;
  localparam int SQ_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 176;

  // The shared multiplier consumes the unsigned operand one digit per cycle.
  localparam int DIGIT_W   = 4;
  localparam int MUL_STEPS = COEF_W / DIGIT_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_ENABLE = 3'd0,
    CFG_HP_COEF   = 3'd1,
    CFG_LP_ENABLE = 3'd2,
    CFG_LP_COEF   = 3'd3,
    CFG_TRIM_GAIN = 3'd4
  } asc_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_POST,
    ST_OUT
  } asc_state_e;

  typedef enum logic [2:0] {
    OP_HP1,
    OP_HP2,
    OP_LP1,
    OP_LP2,
    OP_TRIM,
    OP_SQ_IN,
    OP_SQ_OUT
  } asc_op_e;

  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] coef;
  } asc_mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } asc_mul_stat_t;

  typedef struct packed {
    logic sq_in;
    logic sq_out;
    logic clear;
  } asc_meter_ctrl_t;

endpackage

// ===== rtl/core/asc_mul.sv =====
module asc_mul #(
  parameter int AW = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  asc_pkg::asc_mul_req_t         req_i,
  input  logic signed [AW-1:0]          a_i,
  output asc_pkg::asc_mul_stat_t        stat_o,
  output logic signed [AW+asc_pkg::COEF_W-1:0] prod_o
);
  import asc_pkg::*;

  localparam int PW = AW + COEF_W;

  logic signed [AW-1:0]        a_q;
  logic [COEF_W-1:0]           b_q;
  logic signed [PW-1:0]        prod_q, prod_d;
  logic signed [AW+DIGIT_W:0]  pp;
  logic [MUL_CNT_W-1:0]        cnt_q;

  // Partial product of the signed operand and the current unsigned digit.
  // The running product sits left-aligned and moves right one digit per step,
  // so after the last step it holds the exact product.
  assign pp     = a_q * $signed({1'b0, b_q[DIGIT_W-1:0]});
  assign prod_d = (prod_q >>> DIGIT_W) + (PW'(pp) <<< (COEF_W - DIGIT_W));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= MUL_CNT_W'(MUL_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= a_i;
      b_q    <= req_i.coef;
      prod_q <= '0;
    end else if (cnt_q != '0) begin
      b_q    <= b_q >> DIGIT_W;
      prod_q <= prod_d;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = (cnt_q == MUL_CNT_W'(1));
  assign prod_o      = prod_q;

endmodule

// ===== rtl/core/asc_meter.sv =====
module asc_meter #(
  parameter int COUNT_CAP = 1048576
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  asc_pkg::asc_meter_ctrl_t      ctrl_i,
  input  logic [asc_pkg::PEAK_W-1:0]    mag_i,
  input  logic [asc_pkg::SQ_W-1:0]      sq_i,
  output logic [asc_pkg::PEAK_W-1:0]    peak_in_o,
  output logic [asc_pkg::PEAK_W-1:0]    peak_out_o,
  output logic [asc_pkg::SUMSQ_W-1:0]   sumsq_in_o,
  output logic [asc_pkg::SUMSQ_W-1:0]   sumsq_out_o,
  output logic [asc_pkg::COUNT_W-1:0]   count_o
);
  import asc_pkg::*;

  logic [PEAK_W-1:0]  peak_in_q, peak_out_q;
  logic [SUMSQ_W-1:0] sumsq_in_q, sumsq_out_q, acc_sel, acc_new;
  logic [SUMSQ_W:0]   acc_sum;
  logic [COUNT_W-1:0] count_q;

  // One adder serves both sums; the carry out means the cap was passed.
  always_comb begin
    acc_sel = ctrl_i.sq_in ? sumsq_in_q : sumsq_out_q;
    acc_sum = {1'b0, acc_sel} + (SUMSQ_W+1)'(sq_i);
    acc_new = acc_sum[SUMSQ_W] ? {SUMSQ_W{1'b1}} : acc_sum[SUMSQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_in_q   <= '0;
      peak_out_q  <= '0;
      sumsq_in_q  <= '0;
      sumsq_out_q <= '0;
      count_q     <= '0;
    end else if (ctrl_i.clear) begin
      peak_in_q   <= '0;
      peak_out_q  <= '0;
      sumsq_in_q  <= '0;
      sumsq_out_q <= '0;
      count_q     <= '0;
    end else if (ctrl_i.sq_in) begin
      if (mag_i > peak_in_q) begin
        peak_in_q <= mag_i;
      end
      sumsq_in_q <= acc_new;
      if (count_q < COUNT_W'(COUNT_CAP)) begin
        count_q <= count_q + 1'b1;
      end
    end else if (ctrl_i.sq_out) begin
      if (mag_i > peak_out_q) begin
        peak_out_q <= mag_i;
      end
      sumsq_out_q <= acc_new;
    end
  end

  assign peak_in_o   = peak_in_q;
  assign peak_out_o  = peak_out_q;
  assign sumsq_in_o  = sumsq_in_q;
  assign sumsq_out_o = sumsq_out_q;
  assign count_o     = count_q;

endmodule

// ===== rtl/core/audio_shaping_chain_core.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata[15:0] sample_in, tlast last_in
// m_axis    out  tdata sample_out, peaks, sums of squares, count; tlast last_out
// cfg       in   cfg_index_i register index, cfg_data_i value
//
// Each sample runs 3 + 2*hp_enable + 2*lp_enable multiplies, 3 to 7:
// every multiply (filter sections, trim, two squares) goes through the one
// digit-serial multiplier, with a setup state, its digit steps and a result state.
// Reset clears filter state and clip accumulators and restores the default configuration.
// A finished beat waits in the output register; the next sample can be taken and
// processed meanwhile, and the block holds before writing its result until the slot frees.
module audio_shaping_chain_core #(
  parameter int MAX_CLIP   = 1048576,
  parameter int STATE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample_in [15:0]
  input  logic [15:0]                          s_axis_tdata,
  input  logic                                 s_axis_tlast,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_out [15:0], peak_before [31:16], peak_after [47:32],
  // sumsq_before [98:48], sumsq_after [149:99], sample_count [170:150], zero [175:171]
  output logic [asc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [asc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);
  import asc_pkg::*;

  localparam int SB    = STATE_BITS;
  localparam int FRAC  = SB - 4;
  localparam int SHL   = (FRAC >= 15) ? FRAC - 15 : 0;
  localparam int SHR   = (FRAC < 15) ? 15 - FRAC : 0;
  localparam int MW    = SB + 2;
  localparam int PW    = MW + COEF_W;
  localparam int RW    = PW - 16;
  localparam int TW    = PW - (FRAC - 1);
  localparam int COUNT_CAP = (MAX_CLIP < (2 ** COUNT_W) - 1) ? MAX_CLIP : (2 ** COUNT_W) - 1;
  localparam int PAD_W = OUT_DATA_W - (SAMPLE_W + 2 * PEAK_W + 2 * SUMSQ_W + COUNT_W);

  localparam logic signed [PW-1:0] RND16    = PW'(32768);
  localparam logic signed [PW-1:0] RND_TRIM = PW'(1) <<< (FRAC - 2);
  localparam logic signed [SB-1:0] S_MAX    = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN    = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] to_state(logic signed [SAMPLE_W-1:0] s);
    logic signed [SB-1:0] e;
    e = SB'(s);
    return (e <<< SHL) >>> SHR;
  endfunction

  // Configuration registers.
  logic              hp_en_q, lp_en_q;
  logic [COEF_W-1:0] hp_coef_q, lp_coef_q, trim_q;

  // Control.
  asc_state_e      state_q, state_d;
  asc_op_e         op_q, op_d, first_op;
  asc_mul_req_t    mul_req;
  asc_mul_stat_t   mul_stat;
  asc_meter_ctrl_t meter_ctrl;
  logic            in_acc, out_load;

  // Sample path.
  logic signed [SAMPLE_W-1:0] x_q, y_q;
  logic                       last_q;
  logic signed [SB-1:0]       v_q;
  logic [PEAK_W-1:0]          ax, ay;

  // Filter state.
  logic signed [SAMPLE_W-1:0] hp1_in_q;
  logic signed [SB-1:0]       hp1_out_q, hp2_in_q, hp2_out_q, lp1_q, lp2_q;
  logic                       first_q;

  // Multiplier and result shaping.
  logic                       mul_start;
  logic [COEF_W-1:0]          mul_coef;
  logic signed [MW-1:0]       mul_a;
  logic signed [PW-1:0]       prod, rnd16, rnd_t;
  logic signed [RW-1:0]       q16;
  logic signed [RW:0]         lp_sum;
  logic signed [TW-1:0]       qt;
  logic signed [SB-1:0]       lp_old, hp_sat, lp_sat;
  logic signed [SAMPLE_W-1:0] trim_sat;

  // Meter.
  logic [PEAK_W-1:0]  peak_in, peak_out, meter_mag;
  logic [SUMSQ_W-1:0] sumsq_in, sumsq_out;
  logic [COUNT_W-1:0] count;
  logic [SQ_W-1:0]    meter_sq;

  // Output register.
  logic                  out_valid_q, out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_en_q   <= 1'b0;
      hp_coef_q <= '0;
      lp_en_q   <= 1'b0;
      lp_coef_q <= '0;
      trim_q    <= COEF_W'(16384);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HP_ENABLE: hp_en_q   <= cfg_data_i[0];
        CFG_HP_COEF:   hp_coef_q <= cfg_data_i;
        CFG_LP_ENABLE: lp_en_q   <= cfg_data_i[0];
        CFG_LP_COEF:   lp_coef_q <= cfg_data_i;
        CFG_TRIM_GAIN: trim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign first_op      = hp_en_q ? OP_HP1 : (lp_en_q ? OP_LP1 : OP_TRIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_HP1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    mul_start        = 1'b0;
    meter_ctrl       = '0;
    out_load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_START;
          op_d    = first_op;
        end
      end
      ST_START: begin
        mul_start = 1'b1;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (mul_stat.done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_START;
        case (op_q)
          OP_HP1:  op_d = OP_HP2;
          OP_HP2:  op_d = lp_en_q ? OP_LP1 : OP_TRIM;
          OP_LP1:  op_d = OP_LP2;
          OP_LP2:  op_d = OP_TRIM;
          OP_TRIM: op_d = OP_SQ_IN;
          OP_SQ_IN: begin
            op_d             = OP_SQ_OUT;
            meter_ctrl.sq_in = 1'b1;
          end
          OP_SQ_OUT: begin
            state_d           = ST_OUT;
            meter_ctrl.sq_out = 1'b1;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load         = 1'b1;
          meter_ctrl.clear = last_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- operands
  assign ax = x_q[SAMPLE_W-1] ? PEAK_W'(~x_q + 1'b1) : PEAK_W'(x_q);
  assign ay = y_q[SAMPLE_W-1] ? PEAK_W'(~y_q + 1'b1) : PEAK_W'(y_q);
  assign lp_old = (op_q == OP_LP1) ? lp1_q : lp2_q;

  always_comb begin
    mul_a    = MW'(v_q);
    mul_coef = trim_q;
    case (op_q)
      OP_HP1: begin
        mul_a    = MW'(v_q) + MW'(hp1_out_q) - MW'(to_state(hp1_in_q));
        mul_coef = hp_coef_q;
      end
      OP_HP2: begin
        mul_a    = MW'(v_q) + MW'(hp2_out_q) - MW'(hp2_in_q);
        mul_coef = hp_coef_q;
      end
      OP_LP1, OP_LP2: begin
        mul_a    = MW'(v_q) - MW'(lp_old);
        mul_coef = lp_coef_q;
      end
      OP_TRIM: begin
        mul_a    = MW'(v_q);
        mul_coef = trim_q;
      end
      OP_SQ_IN: begin
        mul_a    = MW'($signed({1'b0, ax}));
        mul_coef = ax;
      end
      OP_SQ_OUT: begin
        mul_a    = MW'($signed({1'b0, ay}));
        mul_coef = ay;
      end
      default: ;
    endcase
  end

  assign mul_req = '{start: mul_start, coef: mul_coef};

  asc_mul #(
    .AW (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  // Round half up, then clamp. A clamp is needed whenever the bits above the
  // target sign bit disagree.
  always_comb begin
    rnd16  = prod + RND16;
    q16    = $signed(rnd16[PW-1:16]);
    if ((q16[RW-1:SB-1] == '0) || (q16[RW-1:SB-1] == '1)) begin
      hp_sat = SB'(q16);
    end else begin
      hp_sat = q16[RW-1] ? S_MIN : S_MAX;
    end

    lp_sum = (RW+1)'(q16) + (RW+1)'(lp_old);
    if ((lp_sum[RW:SB-1] == '0) || (lp_sum[RW:SB-1] == '1)) begin
      lp_sat = SB'(lp_sum);
    end else begin
      lp_sat = lp_sum[RW] ? S_MIN : S_MAX;
    end

    rnd_t = prod + RND_TRIM;
    qt    = $signed(rnd_t[PW-1:FRAC-1]);
    if ((qt[TW-1:SAMPLE_W-1] == '0) || (qt[TW-1:SAMPLE_W-1] == '1)) begin
      trim_sat = SAMPLE_W'(qt);
    end else begin
      trim_sat = qt[TW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= $signed(s_axis_tdata);
      last_q <= s_axis_tlast;
      v_q    <= to_state($signed(s_axis_tdata));
    end else if (state_q == ST_POST) begin
      case (op_q)
        OP_HP1, OP_HP2: v_q <= hp_sat;
        OP_LP1, OP_LP2: v_q <= lp_sat;
        OP_TRIM:        y_q <= trim_sat;
        default: ;
      endcase
    end
  end

  // The first sample of a clip also stands in as the previous input of the
  // first highpass section, whether or not the highpass is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp1_in_q  <= '0;
      hp1_out_q <= '0;
      hp2_in_q  <= '0;
      hp2_out_q <= '0;
      lp1_q     <= '0;
      lp2_q     <= '0;
      first_q   <= 1'b1;
    end else if (out_load && last_q) begin
      hp1_in_q  <= '0;
      hp1_out_q <= '0;
      hp2_in_q  <= '0;
      hp2_out_q <= '0;
      lp1_q     <= '0;
      lp2_q     <= '0;
      first_q   <= 1'b1;
    end else if (in_acc) begin
      if (first_q) begin
        hp1_in_q <= $signed(s_axis_tdata);
      end
      first_q <= 1'b0;
    end else if (state_q == ST_POST) begin
      case (op_q)
        OP_HP1: begin
          hp1_out_q <= hp_sat;
          hp1_in_q  <= x_q;
        end
        OP_HP2: begin
          hp2_in_q  <= v_q;
          hp2_out_q <= hp_sat;
        end
        OP_LP1: lp1_q <= lp_sat;
        OP_LP2: lp2_q <= lp_sat;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- meter
  assign meter_mag = (op_q == OP_SQ_IN) ? ax : ay;
  assign meter_sq  = prod[SQ_W-1:0];

  asc_meter #(
    .COUNT_CAP (COUNT_CAP)
  ) u_meter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (meter_ctrl),
    .mag_i       (meter_mag),
    .sq_i        (meter_sq),
    .peak_in_o   (peak_in),
    .peak_out_o  (peak_out),
    .sumsq_in_o  (sumsq_in),
    .sumsq_out_o (sumsq_out),
    .count_o     (count)
  );

  // ---------------------------------------------------------------- output
  always_comb begin
    if (last_q) begin
      out_data_d = {{PAD_W{1'b0}}, count, sumsq_out, sumsq_in, peak_out, peak_in, y_q};
    end else begin
      out_data_d = {{(OUT_DATA_W-SAMPLE_W){1'b0}}, y_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- checks
  a_stats_zero_mid_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[OUT_DATA_W-1:SAMPLE_W] == '0))
    else $error("measurement fields set on a beat that does not end a clip");

  a_mul_not_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_stat.busy)
    else $error("multiplier started while a product is in progress");

  a_one_sample_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second sample taken while one is in progress");

  a_clip_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meter_ctrl.clear |=> ((count == '0) && first_q && (lp2_q == '0)))
    else $error("clip state not cleared after the last sample");

endmodule
